// ===== rtl/ttem_pkg.sv =====
`timescale 1ns / 1ps

package ttem_pkg;

  // sizes
  localparam int HISTORY_DEPTH_DEF = 65536;
  localparam int SAMPLE_W          = 8;
  localparam int DELAY_W           = 16;
  localparam int GAIN_W            = 8;
  localparam int INDEX_W           = 17;
  localparam int NUM_TAPS          = 3;
  localparam int TAP_W             = 2;
  localparam int CFG_ADDR_W        = 5;
  localparam int CFG_DATA_W        = 32;

  localparam logic [INDEX_W-1:0] INDEX_MAX = 17'd131071;

  // register indexes (byte address is 4 times the index)
  localparam logic [2:0] REG_DELAY_ONE   = 3'd0;
  localparam logic [2:0] REG_GAIN_ONE    = 3'd1;
  localparam logic [2:0] REG_DELAY_TWO   = 3'd2;
  localparam logic [2:0] REG_GAIN_TWO    = 3'd3;
  localparam logic [2:0] REG_DELAY_THREE = 3'd4;
  localparam logic [2:0] REG_GAIN_THREE  = 3'd5;

  // register reset values
  localparam logic [DELAY_W-1:0] DELAY_ONE_RST   = 16'd14666;
  localparam logic [GAIN_W-1:0]  GAIN_ONE_RST    = 8'd128;
  localparam logic [DELAY_W-1:0] DELAY_TWO_RST   = 16'd22000;
  localparam logic [GAIN_W-1:0]  GAIN_TWO_RST    = 8'd102;
  localparam logic [DELAY_W-1:0] DELAY_THREE_RST = 16'd34000;
  localparam logic [GAIN_W-1:0]  GAIN_THREE_RST  = 8'd77;

endpackage

// ===== rtl/three_tap_echo_mixer_top.sv =====
`timescale 1ns / 1ps

// Three-tap feedforward echo mixer for unsigned 8-bit PCM (128 is silence).
// Input channel: in_valid/in_ready carry one word of sample and first flag;
// first restarts the run index. Output channel: out_valid/out_ready carry
// one mixed sample for every input word, in order.
// Each word is written to the history RAM on acceptance, then one shared
// adder does the work: three RAM reads pipelined with three multiply-
// accumulates, a prepare step, a 9-step restoring floor division by
// 256 + g1 + g2 + g3 and an output load. The block takes no new word
// until it is through with the last one; in_ready is high only while the
// sequencer is idle.
// A finished result waits in the output register while the next word is
// accepted; if the receiver still stalls when the next result is ready,
// the sequencer holds in its output step until the register frees.
// Reset (synchronous, rst_n low) clears the run index, write pointer,
// sequencer and output valid, and restores register defaults. The history
// RAM is not cleared: a tap only reads entries already written.
// Registers are at byte addresses 0, 4 .. 20 on the APB-style port.
module three_tap_echo_mixer_top #(
  parameter int HISTORY_DEPTH = ttem_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ttem_pkg::SAMPLE_W-1:0]       in_sample_in,
  input  logic                                in_first,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ttem_pkg::SAMPLE_W-1:0]       out_sample_out,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ttem_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [ttem_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [ttem_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int AW    = $clog2(HISTORY_DEPTH);
  localparam int MOD_W = AW + 9;
  localparam int ACC_W = 18;
  localparam int ALU_W = ACC_W + 1;
  localparam int DEN_W = 10;
  localparam int QUO_W = 9;
  localparam int CNT_W = 4;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TAP  = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  // delay mod depth, by trial subtraction of depth times 128 .. 1
  function automatic logic [AW-1:0] depth_mod(input logic [ttem_pkg::DELAY_W-1:0] d);
    logic [MOD_W-1:0] r;
    r = MOD_W'(d);
    for (int k = 7; k >= 0; k--) begin
      if (r >= (MOD_W'(HISTORY_DEPTH) << k)) begin
        r = r - (MOD_W'(HISTORY_DEPTH) << k);
      end
    end
    return r[AW-1:0];
  endfunction

  // configuration registers
  logic [ttem_pkg::DELAY_W-1:0] delay_r [ttem_pkg::NUM_TAPS];
  logic [ttem_pkg::GAIN_W-1:0]  gain_r  [ttem_pkg::NUM_TAPS];
  logic [AW-1:0]                back_r  [ttem_pkg::NUM_TAPS];

  // sequencer and datapath
  logic [2:0]                   state_r;
  logic [ttem_pkg::TAP_W-1:0]   tap_r;
  logic [CNT_W-1:0]             bit_r;
  logic [ttem_pkg::INDEX_W-1:0] run_index_r;
  logic [ttem_pkg::INDEX_W-1:0] cur_idx_r;
  logic [AW-1:0]                wr_ptr_r;
  logic [AW-1:0]                cur_ptr_r;
  logic signed [ACC_W-1:0]      acc_r;
  logic [DEN_W-1:0]             den_r;
  logic [ACC_W-1:0]             rem_r;
  logic [ACC_W-1:0]             dsh_r;
  logic [QUO_W-1:0]             quo_r;
  logic                         neg_r;
  logic                         out_valid_r;
  logic [ttem_pkg::SAMPLE_W-1:0] out_sample_r;

  logic                         cfg_we;
  logic [2:0]                   cfg_idx;
  logic                         in_accept;
  logic                         out_free;
  logic [ttem_pkg::INDEX_W-1:0] idx_base;
  logic signed [8:0]            c0;
  logic [AW-1:0]                rd_back;
  logic [AW:0]                  wrap_sum;
  logic [AW-1:0]                tap_addr;
  logic [ttem_pkg::SAMPLE_W-1:0] rd_data;
  logic [ttem_pkg::DELAY_W-1:0] mac_delay;
  logic [ttem_pkg::GAIN_W-1:0]  mac_gain;
  logic                         mac_act;
  logic signed [8:0]            mac_c;
  logic signed [8:0]            mac_g;
  logic signed [ACC_W-1:0]      prod;
  logic signed [ALU_W-1:0]      alu_a;
  logic signed [ALU_W-1:0]      alu_b;
  logic signed [ALU_W-1:0]      alu_sum;
  logic [ACC_W-1:0]             acc_mag;
  logic signed [DEN_W-1:0]      q_s;
  logic signed [DEN_W-1:0]      res_s;
  logic [ttem_pkg::SAMPLE_W-1:0] res;

  assign cfg_we    = psel && penable && pwrite && pready;
  assign cfg_idx   = paddr[4:2];
  assign pready    = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  // register read-back
  always_comb begin
    unique case (cfg_idx)
      ttem_pkg::REG_DELAY_ONE:   prdata = 32'(delay_r[0]);
      ttem_pkg::REG_GAIN_ONE:    prdata = 32'(gain_r[0]);
      ttem_pkg::REG_DELAY_TWO:   prdata = 32'(delay_r[1]);
      ttem_pkg::REG_GAIN_TWO:    prdata = 32'(gain_r[1]);
      ttem_pkg::REG_DELAY_THREE: prdata = 32'(delay_r[2]);
      ttem_pkg::REG_GAIN_THREE:  prdata = 32'(gain_r[2]);
      default:                   prdata = '0;
    endcase
  end

  // register writes; wrapped delay kept alongside each delay
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r[0] <= ttem_pkg::DELAY_ONE_RST;
      delay_r[1] <= ttem_pkg::DELAY_TWO_RST;
      delay_r[2] <= ttem_pkg::DELAY_THREE_RST;
      gain_r[0]  <= ttem_pkg::GAIN_ONE_RST;
      gain_r[1]  <= ttem_pkg::GAIN_TWO_RST;
      gain_r[2]  <= ttem_pkg::GAIN_THREE_RST;
      back_r[0]  <= depth_mod(ttem_pkg::DELAY_ONE_RST);
      back_r[1]  <= depth_mod(ttem_pkg::DELAY_TWO_RST);
      back_r[2]  <= depth_mod(ttem_pkg::DELAY_THREE_RST);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        ttem_pkg::REG_DELAY_ONE: begin
          delay_r[0] <= pwdata[15:0];
          back_r[0]  <= depth_mod(pwdata[15:0]);
        end
        ttem_pkg::REG_GAIN_ONE: gain_r[0] <= pwdata[7:0];
        ttem_pkg::REG_DELAY_TWO: begin
          delay_r[1] <= pwdata[15:0];
          back_r[1]  <= depth_mod(pwdata[15:0]);
        end
        ttem_pkg::REG_GAIN_TWO: gain_r[1] <= pwdata[7:0];
        ttem_pkg::REG_DELAY_THREE: begin
          delay_r[2] <= pwdata[15:0];
          back_r[2]  <= depth_mod(pwdata[15:0]);
        end
        ttem_pkg::REG_GAIN_THREE: gain_r[2] <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // index of the incoming word, and its centred value
  assign idx_base = in_first ? '0 : run_index_r;
  assign c0       = signed'({1'b0, in_sample_in}) - 9'sd128;

  // tap address for the read issued this cycle
  always_comb begin
    case (tap_r)
      2'd1:    rd_back = back_r[1];
      2'd2:    rd_back = back_r[2];
      default: rd_back = back_r[0];
    endcase
  end

  assign wrap_sum = {1'b0, cur_ptr_r} + (AW + 1)'(HISTORY_DEPTH) - {1'b0, rd_back};
  assign tap_addr = (cur_ptr_r >= rd_back) ? (cur_ptr_r - rd_back) : wrap_sum[AW-1:0];

  ttem_ram #(
    .WIDTH (ttem_pkg::SAMPLE_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk   (clk),
    .we    (in_accept),
    .waddr (wr_ptr_r),
    .wdata (in_sample_in),
    .raddr (tap_addr),
    .rdata (rd_data)
  );

  // tap whose data comes back this cycle
  always_comb begin
    case (tap_r)
      2'd2: begin
        mac_delay = delay_r[1];
        mac_gain  = gain_r[1];
      end
      2'd3: begin
        mac_delay = delay_r[2];
        mac_gain  = gain_r[2];
      end
      default: begin
        mac_delay = delay_r[0];
        mac_gain  = gain_r[0];
      end
    endcase
  end

  // tap stays silent until the index passes its delay
  assign mac_act = cur_idx_r > {1'b0, mac_delay};
  assign mac_c   = mac_act ? (signed'({1'b0, rd_data}) - 9'sd128) : 9'sd0;
  assign mac_g   = signed'({1'b0, mac_gain});
  assign prod    = mac_c * mac_g;

  // shared adder: accumulate in the tap step, trial subtract in the divide step
  always_comb begin
    if (state_r == S_DIV) begin
      alu_a = signed'({1'b0, rem_r});
      alu_b = -signed'({1'b0, dsh_r});
    end else begin
      alu_a = ALU_W'(acc_r);
      alu_b = ALU_W'(prod);
    end
  end
  assign alu_sum = alu_a + alu_b;

  assign acc_mag = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);

  // signed quotient, re-offset and clamp
  assign q_s   = neg_r ? -signed'({1'b0, quo_r}) : signed'({1'b0, quo_r});
  assign res_s = q_s + 10'sd128;
  always_comb begin
    if (res_s < 10'sd0) begin
      res = '0;
    end else if (res_s > 10'sd255) begin
      res = '1;
    end else begin
      res = res_s[7:0];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tap_r       <= '0;
      bit_r       <= '0;
      run_index_r <= '0;
      wr_ptr_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // output register: load from the output step, else clear once taken
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            run_index_r <= (idx_base == ttem_pkg::INDEX_MAX) ? idx_base : idx_base + 1'b1;
            wr_ptr_r    <= (wr_ptr_r == AW'(HISTORY_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
            tap_r       <= '0;
            state_r     <= S_TAP;
          end
        end
        S_TAP: begin
          if (tap_r == 2'd3) begin
            state_r <= S_PREP;
          end else begin
            tap_r <= tap_r + 1'b1;
          end
        end
        S_PREP: begin
          bit_r   <= CNT_W'(QUO_W - 1);
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (bit_r == '0) begin
            state_r <= S_OUT;
          end else begin
            bit_r <= bit_r - 1'b1;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          cur_idx_r <= idx_base;
          cur_ptr_r <= wr_ptr_r;
          acc_r     <= {c0[8], c0, 8'b0};
          den_r     <= 10'd256 + DEN_W'(gain_r[0]) + DEN_W'(gain_r[1]) + DEN_W'(gain_r[2]);
        end
      end
      S_TAP: begin
        if (tap_r != 2'd0) begin
          acc_r <= alu_sum[ACC_W-1:0];
        end
      end
      S_PREP: begin
        // negative sums round towards minus infinity: bias by den - 1
        neg_r <= acc_r[ACC_W-1];
        rem_r <= acc_mag + (acc_r[ACC_W-1] ? ACC_W'(den_r - 1'b1) : '0);
        dsh_r <= ACC_W'(den_r) << (QUO_W - 1);
        quo_r <= '0;
      end
      S_DIV: begin
        if (!alu_sum[ALU_W-1]) begin
          rem_r <= alu_sum[ACC_W-1:0];
        end
        quo_r <= {quo_r[QUO_W-2:0], ~alu_sum[ALU_W-1]};
        dsh_r <= dsh_r >> 1;
      end
      S_OUT: begin
        if (out_free) begin
          out_sample_r <= res;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/ttem_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port, registered read data
module ttem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ttem_checker.sv =====
`timescale 1ns / 1ps

// Port-level checks for the echo mixer
module ttem_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ttem_pkg::SAMPLE_W-1:0] out_sample_out,
  input logic                          pready
);

  // reset empties the output register
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // the shared unit is busy once a word is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("word accepted while sequencer busy");

  // a result never appears straight after acceptance
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result produced too early");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_sample_out)))
    else $error("stalled output word changed");

  // configuration port never waits while an input word is offered
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid |-> pready)
    else $error("pready low");

endmodule

bind three_tap_echo_mixer_top ttem_checker u_ttem_checker (.*);
